FILE: rtl/etpf_pkg.sv
// etpf_pkg: shared types, constants, crc and steering helpers for the telemetry framer
// depends on nothing; imported by every module under rtl
package etpf_pkg;

    // frame layout
    localparam int FRAME_BYTES = 50;
    localparam int CRC_SPAN    = 48;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] STEER_ERR  = 16'hFFFF;
    localparam logic [15:0] PERIOD_RST = 16'd20;

    // header bytes, first byte in the low bits
    localparam logic [63:0] FRAME_HEADER = {8'h00, 8'(FRAME_BYTES), 8'h01, 8'h01,
                                            8'h31, 8'h43, 8'h4E, 8'h45};

    // configuration register indexes (paddr[2])
    localparam logic REG_SEND_ENABLE = 1'b0;
    localparam logic REG_PERIOD_MS   = 1'b1;
    localparam int   CFG_ADDR_W      = 3;

    // input beat
    typedef struct packed {
        logic        [31:0] now_ms;
        logic signed [31:0] drive_front_right;
        logic signed [31:0] drive_rear_right;
        logic signed [31:0] drive_rear_left;
        logic signed [31:0] drive_front_left;
        logic        [15:0] steer_front_right;
        logic        [15:0] steer_rear_right;
        logic        [15:0] steer_rear_left;
        logic        [15:0] steer_front_left;
    } t_tick;

    // result beat
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_result;

    // one accepted frame, words already in wire form
    typedef struct packed {
        logic [31:0] steer_fl;
        logic [31:0] steer_rl;
        logic [31:0] steer_rr;
        logic [31:0] steer_fr;
        logic [31:0] drive_fl;
        logic [31:0] drive_rl;
        logic [31:0] drive_rr;
        logic [31:0] drive_fr;
        logic [31:0] now_ms;
        logic [31:0] seq;
    } t_desc;

    // crc-16 ccitt, one byte, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // steering reading to 32-bit word, error code becomes -1
    function automatic logic [31:0] steer_word(input logic [15:0] s);
        return (s == STEER_ERR) ? 32'hFFFF_FFFF : {16'h0000, s};
    endfunction

endpackage

FILE: rtl/encoder_telemetry_packet_framer.sv
// encoder_telemetry_packet_framer: top level, config registers and front/queue/back wiring
// depends on etpf_pkg, etpf_front, etpf_queue, etpf_back
//
//  channel   handshake            payload          beat
//  ticks     push / full          i_tick (t_tick)  one tick per beat
//  frames    pop / empty          o_frame          one frame byte per beat
//  config    psel/penable/pwrite  pwdata / prdata  register at 4*index
//
// a tick is accepted whenever the descriptor queue has room
// a sent frame leaves as 50 bytes, one per cycle while the output is taken, set by the byte serializer
// the crc advances one byte per cycle alongside the serializer, and holds while the output stalls
// reset (synchronous, low) clears sequence, send time, queue and output, and restores the config registers
// output stalls back up into the queue; full rises only when it is full
module encoder_telemetry_packet_framer
    import etpf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_tick                 i_tick,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_frame,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic        r_send_enable;
    logic [15:0] r_period_ms;
    logic        cfg_wr;
    logic        q_push, q_full, q_valid, q_pop;
    t_desc       q_in, q_out;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_enable <= 1'b0;
            r_period_ms   <= PERIOD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SEND_ENABLE) begin
                r_send_enable <= pwdata[0];
            end else begin
                r_period_ms <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_PERIOD_MS) begin
            prdata = {16'h0000, r_period_ms};
        end else begin
            prdata = {31'h0, r_send_enable};
        end
    end

    etpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_tick        (i_tick),
        .i_send_enable (r_send_enable),
        .i_period_ms   (r_period_ms),
        .i_q_full      (q_full),
        .o_full        (full),
        .o_q_push      (q_push),
        .o_q_desc      (q_in)
    );

    etpf_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_out),
        .i_pop   (q_pop)
    );

    etpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (q_out),
        .o_q_pop   (q_pop),
        .o_frame   (o_frame),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    // front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("descriptor queue written while full");

    // back never retires a descriptor that is not there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("descriptor queue popped while empty");

    // nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result offered after reset");

endmodule

FILE: rtl/etpf_front.sv
// etpf_front: accepts ticks, decides whether a frame is due, keeps sequence and send time
// depends on etpf_pkg
module etpf_front
    import etpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_tick       i_tick,
    input  logic        i_send_enable,
    input  logic [15:0] i_period_ms,
    input  logic        i_q_full,
    output logic        o_full,
    output logic        o_q_push,
    output t_desc       o_q_desc
);

    logic [31:0] r_seq, n_seq;
    logic [31:0] r_last, n_last;
    logic [31:0] elapsed;
    logic        accept;
    logic        due;

    // period check on wrapping difference
    assign elapsed = i_tick.now_ms - r_last;
    assign due     = i_send_enable && (elapsed >= {16'h0000, i_period_ms});
    assign accept  = i_push && !i_q_full;
    assign o_full  = i_q_full;
    assign o_q_push = accept && due;

    // frame descriptor
    always_comb begin
        o_q_desc.seq      = r_seq;
        o_q_desc.now_ms   = i_tick.now_ms;
        o_q_desc.drive_fr = i_tick.drive_front_right;
        o_q_desc.drive_rr = i_tick.drive_rear_right;
        o_q_desc.drive_rl = i_tick.drive_rear_left;
        o_q_desc.drive_fl = i_tick.drive_front_left;
        o_q_desc.steer_fr = steer_word(i_tick.steer_front_right);
        o_q_desc.steer_rr = steer_word(i_tick.steer_rear_right);
        o_q_desc.steer_rl = steer_word(i_tick.steer_rear_left);
        o_q_desc.steer_fl = steer_word(i_tick.steer_front_left);
    end

    // sequence and last send time advance on each queued frame
    always_comb begin
        n_seq  = r_seq;
        n_last = r_last;
        if (o_q_push) begin
            n_seq  = r_seq + 32'd1;
            n_last = i_tick.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= '0;
            r_last <= '0;
        end else begin
            r_seq  <= n_seq;
            r_last <= n_last;
        end
    end

endmodule

FILE: rtl/etpf_queue.sv
// etpf_queue: short queue of frame descriptors between front and back
// depends on etpf_pkg
module etpf_queue
    import etpf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    output logic  o_valid,
    output t_desc o_desc,
    input  logic  i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

endmodule

FILE: rtl/etpf_back.sv
// etpf_back: serializes one descriptor into frame bytes with a running crc
// depends on etpf_pkg
module etpf_back
    import etpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_desc   i_q_desc,
    output logic    o_q_pop,
    output t_result o_frame,
    output logic    o_empty,
    input  logic    i_pop
);

    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(CRC_SPAN);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_BYTES - 1);

    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [15:0]           r_crc, n_crc;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out;
    logic [8*CRC_SPAN-1:0] body;
    logic [15:0]           crc_base;
    logic [7:0]            cur_byte;
    logic                  advance;

    // output register frees when empty or being taken
    assign advance = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop = advance && (r_idx == IDX_LAST);
    assign o_empty = !r_out_valid;
    assign o_frame = r_out;

    // crc-covered part of the frame, first byte in the low bits
    assign body = {i_q_desc.steer_fl, i_q_desc.steer_rl, i_q_desc.steer_rr,
                   i_q_desc.steer_fr, i_q_desc.drive_fl, i_q_desc.drive_rl,
                   i_q_desc.drive_rr, i_q_desc.drive_fr, i_q_desc.now_ms,
                   i_q_desc.seq, FRAME_HEADER};

    // byte select: body, then crc low, then crc high
    always_comb begin
        if (r_idx < IDX_CRC_LO) begin
            cur_byte = body[{r_idx, 3'b000} +: 8];
        end else if (r_idx == IDX_CRC_LO) begin
            cur_byte = r_crc[7:0];
        end else begin
            cur_byte = r_crc[15:8];
        end
    end

    // crc restarts on the first byte of each frame
    assign crc_base = (r_idx == '0) ? CRC_INIT : r_crc;

    always_comb begin
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
            n_idx       = (r_idx == IDX_LAST) ? '0 : r_idx + IDX_W'(1);
            if (r_idx < IDX_CRC_LO) begin
                n_crc = crc16_byte(crc_base, cur_byte);
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        if (advance) begin
            r_out.frame_byte <= cur_byte;
            r_out.frame_last <= (r_idx == IDX_LAST);
        end
    end

endmodule
